[design/bbv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbv_pkg: shared types and constants for the Bernstein basis value unit
// Field widths, register codes, controller/datapath command and status.
// ----------------------------------------------------------------------------
package bbv_pkg;

  localparam int ROW_W     = 11;  // row_count register
  localparam int BASIS_W   = 5;   // basis_count register, also order width
  localparam int ROW_IDX_W = 10;  // row_index field
  localparam int COL_W     = 4;   // column_index field
  localparam int VAL_W     = 17;  // basis_value field, Q1.16
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = ROW_W;

  localparam int VALUE_MAX = 65536;

  localparam int DEF_MAX_ROWS  = 1024;
  localparam int DEF_MAX_BASIS = 16;
  localparam int DEF_FRAC_BITS = 32;

  localparam int ROW_RESET   = 1024;
  localparam int BASIS_RESET = 16;

  // multiplier operand B is consumed CHUNK_W bits per cycle
  localparam int CHUNK_W     = 24;
  localparam int CHUNK_SEL_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASIS_COUNT = 1'b1;

  typedef enum logic [1:0] {
    MSRC_T,
    MSRC_U,
    MSRC_C
  } msrc_t;

  typedef struct packed {
    logic                   load;
    logic                   div_step;
    logic                   pas_step;
    logic                   mul_en;
    logic                   mul_first;
    msrc_t                  mul_src;
    logic [CHUNK_SEL_W-1:0] chunk;
    logic                   p_load;
    logic                   out_load;
  } cmd_t;

  typedef struct packed {
    logic               bad;
    logic [COL_W-1:0]   col;
    logic [BASIS_W-1:0] order;
  } stat_t;

  function automatic int chunk_count(input int frac_bits, input int max_basis);
    int mb;
    mb = (frac_bits + 1 > max_basis) ? frac_bits + 1 : max_basis;
    return (mb + CHUNK_W - 1) / CHUNK_W;
  endfunction

endpackage

[design/bbv_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbv_ctrl: sequencer for the Bernstein basis value unit
// Steps the divider, the power chain, the binomial multiply and the output.
// ----------------------------------------------------------------------------
module bbv_ctrl #(
  parameter int FRAC_BITS = bbv_pkg::DEF_FRAC_BITS,
  parameter int NCH       = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bbv_pkg::stat_t stat,
  output bbv_pkg::cmd_t  cmd
);

  localparam int CW = $clog2(FRAC_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_POW,
    ST_BIN,
    ST_RES
  } state_t;

  state_t                           state;
  logic [CW-1:0]                    cnt;
  logic [bbv_pkg::CHUNK_SEL_W-1:0]  ch;
  logic [bbv_pkg::BASIS_W-1:0]      mcnt;
  logic [bbv_pkg::BASIS_W-1:0]      pcnt;
  logic                             out_valid_q;

  localparam logic [bbv_pkg::CHUNK_SEL_W-1:0] CH_TOP = bbv_pkg::CHUNK_SEL_W'(NCH - 1);

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = out_valid_q;

  always_comb begin
    cmd           = '0;
    cmd.mul_src   = bbv_pkg::MSRC_T;
    cmd.chunk     = ch;
    cmd.load      = in_valid && (state == ST_IDLE);
    cmd.div_step  = (state == ST_DIV) && !stat.bad;
    cmd.pas_step  = ((state == ST_DIV) || (state == ST_POW)) && !stat.bad &&
                    (pcnt < stat.order);
    unique case (state)
      ST_POW: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_first = (ch == CH_TOP);
        cmd.mul_src   = (mcnt < {1'b0, stat.col}) ? bbv_pkg::MSRC_T : bbv_pkg::MSRC_U;
        cmd.p_load    = (ch == '0);
      end
      ST_BIN: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_first = (ch == CH_TOP);
        cmd.mul_src   = bbv_pkg::MSRC_C;
      end
      ST_RES: begin
        cmd.out_load  = !out_valid_q || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      ch          <= '0;
      mcnt        <= '0;
      pcnt        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready) begin
        out_valid_q <= 1'b0;
      end
      if (cmd.pas_step) begin
        pcnt <= pcnt + 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_DIV;
            cnt   <= '0;
            pcnt  <= '0;
          end
        end
        ST_DIV: begin
          if (stat.bad) begin
            state <= ST_RES;
          end else if (cnt == CW'(FRAC_BITS - 1)) begin
            ch   <= CH_TOP;
            mcnt <= '0;
            state <= (stat.order == '0) ? ST_BIN : ST_POW;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_POW: begin
          if (ch == '0) begin
            ch <= CH_TOP;
            if (mcnt == stat.order - 1'b1) begin
              state <= ST_BIN;
            end else begin
              mcnt <= mcnt + 1'b1;
            end
          end else begin
            ch <= ch - 1'b1;
          end
        end
        ST_BIN: begin
          if (ch == '0) begin
            state <= ST_RES;
          end else begin
            ch <= ch - 1'b1;
          end
        end
        ST_RES: begin
          if (cmd.out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Pascal row must be complete before the binomial is read
  a_pascal_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BIN) |-> (pcnt == stat.order))
    else $error("binomial row not finished");

  a_pow_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POW) |-> (mcnt < stat.order))
    else $error("power step beyond order");

  a_bad_skip: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && stat.bad) |=> (state == ST_RES))
    else $error("bad index not sent straight to result");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid_q || out_ready))
    else $error("output register overwritten");
`endif

endmodule

[design/bbv_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbv_dp: datapath for the Bernstein basis value unit
// Config registers, restoring divider, Pascal row, chunked multiplier, rounding.
// ----------------------------------------------------------------------------
module bbv_dp #(
  parameter int MAX_ROWS  = bbv_pkg::DEF_MAX_ROWS,
  parameter int MAX_BASIS = bbv_pkg::DEF_MAX_BASIS,
  parameter int FRAC_BITS = bbv_pkg::DEF_FRAC_BITS,
  parameter int NCH       = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bbv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bbv_pkg::CFG_W-1:0]         cfg_data,
  input  logic [bbv_pkg::ROW_IDX_W-1:0]     row_index,
  input  logic [bbv_pkg::COL_W-1:0]         column_index,
  output logic [bbv_pkg::VAL_W-1:0]         basis_value,
  output logic                              bad_index,
  input  bbv_pkg::cmd_t                     cmd,
  output bbv_pkg::stat_t                    stat
);

  localparam int ROW_W  = bbv_pkg::ROW_W;
  localparam int BAS_W  = bbv_pkg::BASIS_W;
  localparam int PW     = FRAC_BITS + 1;
  localparam int CH_W   = bbv_pkg::CHUNK_W;
  localparam int BP     = NCH * CH_W;
  localparam int AW     = PW + BP;
  localparam int BIN_W  = MAX_BASIS;
  localparam int IDX_W  = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
  localparam int SH     = FRAC_BITS - 16;
  localparam logic [PW-1:0] ONE  = PW'(1) << FRAC_BITS;
  localparam logic [AW:0]   HALF = ((AW + 1)'(1) << SH) >> 1;

  logic [ROW_W-1:0]          row_count_q;
  logic [BAS_W-1:0]          basis_count_q;
  logic [ROW_W-1:0]          rows_eff;
  logic [BAS_W-1:0]          k_eff;
  logic [ROW_W-1:0]          d_in;
  logic                      q0;

  logic [ROW_W-1:0]          d_q;
  logic [ROW_W-1:0]          rem;
  logic [bbv_pkg::COL_W-1:0] col_q;
  logic [BAS_W-1:0]          ord_q;
  logic                      bad_q;
  logic [PW-1:0]             t_q;
  logic [PW-1:0]             u;
  logic [PW-1:0]             p_q;
  logic [AW-1:0]             acc;
  logic [BIN_W-1:0]          pas [MAX_BASIS];

  logic [ROW_W:0]            rem2;
  logic                      ge;
  logic [BP-1:0]             b_full;
  logic [CH_W-1:0]           chunk;
  logic [PW+CH_W-1:0]        prodp;
  logic [AW-1:0]             acc_next;
  logic [AW:0]               rnd;
  logic [AW:0]               vfull;
  logic [bbv_pkg::VAL_W-1:0] val;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count_q   <= ROW_W'(bbv_pkg::ROW_RESET);
      basis_count_q <= BAS_W'(bbv_pkg::BASIS_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbv_pkg::CFG_ROW_COUNT:   row_count_q   <= cfg_data;
        bbv_pkg::CFG_BASIS_COUNT: basis_count_q <= cfg_data[BAS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (row_count_q < ROW_W'(2)) begin
      rows_eff = ROW_W'(2);
    end else if (32'(row_count_q) > MAX_ROWS) begin
      rows_eff = ROW_W'(MAX_ROWS);
    end else begin
      rows_eff = row_count_q;
    end
    if (basis_count_q == '0) begin
      k_eff = BAS_W'(1);
    end else if (32'(basis_count_q) > MAX_BASIS) begin
      k_eff = BAS_W'(MAX_BASIS);
    end else begin
      k_eff = basis_count_q;
    end
  end

  assign d_in = rows_eff - 1'b1;
  assign q0   = ({1'b0, row_index} >= d_in);

  // divider step: t = (j << FRAC_BITS) / (rows-1), one quotient bit a cycle
  assign rem2 = {rem, 1'b0};
  assign ge   = (rem2 >= {1'b0, d_q});
  assign u    = ONE - t_q;

  always_comb begin
    case (cmd.mul_src)
      bbv_pkg::MSRC_T: b_full = BP'(t_q);
      bbv_pkg::MSRC_U: b_full = BP'(u);
      bbv_pkg::MSRC_C: b_full = BP'(pas[IDX_W'(col_q)]);
      default:         b_full = '0;
    endcase
  end

  assign chunk    = b_full[cmd.chunk*CH_W +: CH_W];
  assign prodp    = p_q * chunk;
  assign acc_next = (cmd.mul_first ? '0 : (acc << CH_W)) + AW'(prodp);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_q   <= d_in;
      col_q <= column_index;
      ord_q <= k_eff - 1'b1;
      bad_q <= ({1'b0, row_index} >= rows_eff) || ({1'b0, column_index} >= k_eff);
      rem   <= ROW_W'({1'b0, row_index} - (q0 ? d_in : '0));
      t_q   <= PW'(q0);
      p_q   <= ONE;
    end else begin
      if (cmd.div_step) begin
        rem <= ROW_W'(ge ? rem2 - {1'b0, d_q} : rem2);
        t_q <= {t_q[PW-2:0], ge};
      end
      if (cmd.p_load) begin
        p_q <= acc_next[FRAC_BITS +: PW];
      end
    end
    if (cmd.mul_en) begin
      acc <= acc_next;
    end
  end

  // Pascal row built in place: C(order, k) after order steps
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < MAX_BASIS; k++) begin
        pas[k] <= (k == 0) ? BIN_W'(1) : '0;
      end
    end else if (cmd.pas_step) begin
      for (int k = 1; k < MAX_BASIS; k++) begin
        pas[k] <= pas[k] + pas[k-1];
      end
    end
  end

  // round half up to Q1.16, saturate at 1.0
  assign rnd   = {1'b0, acc} + HALF;
  assign vfull = rnd >> SH;
  assign val   = (vfull > (AW + 1)'(bbv_pkg::VALUE_MAX)) ?
                 bbv_pkg::VAL_W'(bbv_pkg::VALUE_MAX) : vfull[bbv_pkg::VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      basis_value <= bad_q ? '0 : val;
      bad_index   <= bad_q;
    end
  end

  assign stat.bad   = bad_q;
  assign stat.col   = col_q;
  assign stat.order = ord_q;

endmodule

[design/bernstein_basis_value.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bernstein_basis_value: one entry of a Bernstein basis matrix
// Returns C(order,i) * t^i * (1-t)^(order-i), t = j/(rows-1), as Q1.16.
// ----------------------------------------------------------------------------
// Channel   Handshake             Payload
// in        in_valid/in_ready     row_index[9:0], column_index[3:0]
// out       out_valid/out_ready   basis_value[16:0], bad_index
// cfg       cfg_we                cfg_index[0], cfg_data[10:0]
//
// An item passes through the bit-serial divider, the chunked power multiplier
// and the binomial multiply between acceptance and output valid; the multiplier
// takes operand B in NCH = ceil(max(FRAC_BITS + 1, MAX_BASIS) / 24) chunks.
// A bad index skips the divider, power and binomial steps and goes straight
// to the result.
// A new request is taken while the previous result waits in the output
// register; a stalled output holds the next result in the datapath while the sequencer waits in its result state.
// Synchronous reset restores row_count 1024 and basis_count 16.
// ----------------------------------------------------------------------------
module bernstein_basis_value #(
  parameter int MAX_ROWS  = bbv_pkg::DEF_MAX_ROWS,
  parameter int MAX_BASIS = bbv_pkg::DEF_MAX_BASIS,
  parameter int FRAC_BITS = bbv_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bbv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbv_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bbv_pkg::ROW_IDX_W-1:0]  row_index,
  input  logic [bbv_pkg::COL_W-1:0]      column_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bbv_pkg::VAL_W-1:0]      basis_value,
  output logic                           bad_index
);

  localparam int NCH = bbv_pkg::chunk_count(FRAC_BITS, MAX_BASIS);

  bbv_pkg::cmd_t  cmd;
  bbv_pkg::stat_t stat;

  bbv_ctrl #(
    .FRAC_BITS (FRAC_BITS),
    .NCH       (NCH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bbv_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_BASIS (MAX_BASIS),
    .FRAC_BITS (FRAC_BITS),
    .NCH       (NCH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .row_index    (row_index),
    .column_index (column_index),
    .basis_value  (basis_value),
    .bad_index    (bad_index),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

[sim/bernstein_basis_value_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bernstein_basis_value_tb: self-checking bench for the Bernstein basis unit
// Sends row/column requests over the valid/ready channels under a series of
// row and basis count settings, extremes and out-of-range values included.
// An independent fixed-point predictor works out each Q1.16 entry and its
// range flag. Results are compared in order. Random idle bursts on both sides
// and one long output stall exercise back-pressure.
// ----------------------------------------------------------------------------
module bernstein_basis_value_tb;

  localparam int VAL_W     = bbv_pkg::VAL_W;
  localparam int ROW_W     = bbv_pkg::ROW_W;
  localparam int BASIS_W   = bbv_pkg::BASIS_W;
  localparam int CFG_IDX_W = bbv_pkg::CFG_IDX_W;
  localparam int CFG_W     = bbv_pkg::CFG_W;
  localparam int ROW_IDX_W = bbv_pkg::ROW_IDX_W;
  localparam int COL_W     = bbv_pkg::COL_W;

  localparam int N_PHASES       = 12;
  localparam int PHASE_REQUESTS = 128;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [63:0] FIX_ONE = 64'h1_0000_0000;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             bad;
  } basis_result_t;

  class basis_scoreboard;
    logic [ROW_W-1:0]   row_count_q;
    logic [BASIS_W-1:0] basis_count_q;
    basis_result_t      pending_results[$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        flagged;

    function new();
      row_count_q   = ROW_W'(bbv_pkg::ROW_RESET);
      basis_count_q = BASIS_W'(bbv_pkg::BASIS_RESET);
      mismatches    = 0;
      checked       = 0;
      flagged       = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == bbv_pkg::CFG_ROW_COUNT) row_count_q = data;
      else if (idx == bbv_pkg::CFG_BASIS_COUNT) basis_count_q = data[BASIS_W-1:0];
    endfunction

    function int eff_rows();
      if (row_count_q < 2) return 2;
      if (row_count_q > bbv_pkg::DEF_MAX_ROWS) return bbv_pkg::DEF_MAX_ROWS;
      return int'(row_count_q);
    endfunction

    function int eff_basis();
      if (basis_count_q < 1) return 1;
      if (basis_count_q > bbv_pkg::DEF_MAX_BASIS) return bbv_pkg::DEF_MAX_BASIS;
      return int'(basis_count_q);
    endfunction

    // Q32 multiply, truncated
    function logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[95:32];
    endfunction

    function logic [63:0] binomial(int n, int k);
      logic [63:0] c;
      int m;
      c = 64'd1;
      for (m = 0; m < k; m++) c = c * 64'(n - m) / 64'(m + 1);
      return c;
    endfunction

    function void note_request(logic [ROW_IDX_W-1:0] row, logic [COL_W-1:0] col);
      basis_result_t entry;
      int rows, order, falls, m;
      logic [63:0] t, u, p;
      logic [127:0] prod;
      rows  = eff_rows();
      order = eff_basis() - 1;
      entry = '0;
      if (int'(row) >= rows || int'(col) > order) begin
        entry.bad = 1'b1;
      end else begin
        t     = ({54'd0, row} << 32) / 64'(rows - 1);
        u     = FIX_ONE - t;
        p     = FIX_ONE;
        falls = order - int'(col);
        for (m = 0; m < int'(col); m++) p = fix_mul(p, t);
        for (m = 0; m < falls; m++) p = fix_mul(p, u);
        // round half up to Q1.16, saturate at 1.0
        prod = {64'd0, binomial(order, int'(col))} * {64'd0, p} + (128'd1 << 15);
        prod = prod >> 16;
        entry.value = (prod > 128'(bbv_pkg::VALUE_MAX)) ?
                      VAL_W'(bbv_pkg::VALUE_MAX) : prod[VAL_W-1:0];
      end
      pending_results.push_back(entry);
    endfunction

    function void check_result(logic [VAL_W-1:0] value, logic bad);
      basis_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: basis_value %0d, bad_index %0b",
               value, bad);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (want.bad) flagged++;
      if (value !== want.value) begin
        $error("basis_value mismatch: expected %0d, actual %0d", want.value, value);
        mismatches++;
      end
      if (bad !== want.bad) begin
        $error("bad_index mismatch: expected %0b, actual %0b", want.bad, bad);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ROW_IDX_W-1:0] row_index = '0;
  logic [COL_W-1:0]     column_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VAL_W-1:0]     basis_value;
  logic                 bad_index;

  basis_scoreboard sb;
  bit              idle_enabled = 1'b1;
  bit              hold_off_due = 1'b0;
  int              idle_cycles = 0;

  bernstein_basis_value u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .row_index    (row_index),
    .column_index (column_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .basis_value  (basis_value),
    .bad_index    (bad_index)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_request(input logic [ROW_IDX_W-1:0] row,
                              input logic [COL_W-1:0] col);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    row_index    <= row;
    column_index <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(row, col);
  endtask

  // drop valid and wait until every request has returned
  task automatic drain_block();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_register(idx, data);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int ph, n, r, k, sel;
    logic [ROW_W-1:0]     rows_set;
    logic [BASIS_W-1:0]   basis_set;
    logic [CFG_W-1:0]     cfg_word;
    logic [ROW_IDX_W-1:0] row;
    logic [COL_W-1:0]     col;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: corners of t and of the column range
    send_request(10'd0, 4'd0);
    send_request(10'd0, 4'd15);
    send_request(10'd1023, 4'd0);
    send_request(10'd1023, 4'd15);
    send_request(10'd511, 4'd7);
    send_request(10'd512, 4'd8);
    send_request(10'd1, 4'd1);
    send_request(10'd1022, 4'd14);

    // two rows, order zero: 0^0 and range flags
    drain_block();
    write_register(bbv_pkg::CFG_ROW_COUNT, 11'd2);
    write_register(bbv_pkg::CFG_BASIS_COUNT, 11'd1);
    send_request(10'd0, 4'd0);
    send_request(10'd1, 4'd0);
    send_request(10'd2, 4'd0);
    send_request(10'd0, 4'd1);
    send_request(10'd1023, 4'd15);

    // zero counts clamp up; upper data bits ignored for basis count
    drain_block();
    write_register(bbv_pkg::CFG_ROW_COUNT, 11'd0);
    write_register(bbv_pkg::CFG_BASIS_COUNT, 11'h7E0);
    send_request(10'd0, 4'd0);
    send_request(10'd1, 4'd0);
    send_request(10'd1, 4'd1);

    // all-ones counts clamp down
    drain_block();
    write_register(bbv_pkg::CFG_ROW_COUNT, 11'h7FF);
    write_register(bbv_pkg::CFG_BASIS_COUNT, 11'd31);
    send_request(10'd1023, 4'd15);
    send_request(10'd0, 4'd15);
    send_request(10'd1023, 4'd0);
    send_request(10'd341, 4'd5);

    for (ph = 0; ph < N_PHASES; ph++) begin
      drain_block();
      case (ph)
        0: begin rows_set = 11'd1024; basis_set = 5'd16; end
        1: begin rows_set = 11'd2;    basis_set = 5'd16; end
        2: begin rows_set = 11'd3;    basis_set = 5'd2;  end
        3: begin rows_set = 11'd2047; basis_set = 5'd31; end
        4: begin rows_set = 11'd1;    basis_set = 5'd0;  end
        5: begin rows_set = 11'd1025; basis_set = 5'd17; end
        6: begin rows_set = 11'd1023; basis_set = 5'd1;  end
        default: begin
          rows_set  = $urandom_range(0, 1) ? ROW_W'($urandom_range(0, 40)) :
                                             ROW_W'($urandom_range(0, 2047));
          basis_set = BASIS_W'($urandom_range(0, 31));
        end
      endcase
      cfg_word = CFG_W'($urandom_range(0, 2047));
      cfg_word[BASIS_W-1:0] = basis_set;
      write_register(bbv_pkg::CFG_ROW_COUNT, rows_set);
      write_register(bbv_pkg::CFG_BASIS_COUNT, cfg_word);
      idle_enabled = (ph < N_PHASES - 2);
      if (ph == 1) hold_off_due = 1'b1;
      r = sb.eff_rows();
      k = sb.eff_basis();
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        sel = $urandom_range(0, 19);
        row = ROW_IDX_W'($urandom_range(0, r - 1));
        col = COL_W'($urandom_range(0, k - 1));
        if (sel == 0) row = 10'd0;
        if (sel == 1) row = ROW_IDX_W'(r - 1);
        if (sel == 2) col = 4'd0;
        if (sel == 3) col = COL_W'(k - 1);
        if (sel >= 16) begin
          row = ROW_IDX_W'($urandom_range(0, 1023));
          col = COL_W'($urandom_range(0, 15));
          if (sel == 19 && r < 1024) row = ROW_IDX_W'($urandom_range(r, 1023));
          if (sel == 18 && k < 16) col = COL_W'($urandom_range(k, 15));
        end
        send_request(row, col);
      end
    end

    drain_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d count settings incl. clamped extremes; %0d entries checked, %0d flagged",
             N_PHASES + 4, sb.checked, sb.flagged);
    $display("Random idling on both channels and one %0d-cycle output stall", LONG_HOLD);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : receiver
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_off_due) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_due = 1'b0;
      end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(basis_value, bad_index);
  end

  // no request moving on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[filelist.f]
design/bbv_pkg.sv
design/bbv_ctrl.sv
design/bbv_dp.sv
design/bernstein_basis_value.sv
sim/bernstein_basis_value_tb.sv
